### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/tccw_pkg.sv
// ----------------------------------------------------------------------------
// tccw_pkg
// Types, codes and defaults of the text console character writer.
// ----------------------------------------------------------------------------
`default_nettype none

package tccw_pkg;

    localparam int SCREEN_COLS_DEF = 80;
    localparam int SCREEN_ROWS_DEF = 25;
    localparam int VMEM_CELLS_DEF  = 16384;
    localparam int TAB_STOP_DEF    = 4;

    localparam int OFFSET_W    = 14;
    localparam int CELL_IDX_W  = 14;
    localparam int COLUMN_W    = 7;
    localparam int ROW_W       = 5;
    localparam int CELL_W      = 16;
    localparam int CHAR_W      = 8;
    localparam int REQ_W       = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [REQ_W-1:0] REQ_PUT   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

    localparam logic [CHAR_W-1:0] CH_NUL = 8'd0;
    localparam logic [CHAR_W-1:0] CH_BS  = 8'd8;
    localparam logic [CHAR_W-1:0] CH_HT  = 8'd9;
    localparam logic [CHAR_W-1:0] CH_LF  = 8'd10;
    localparam logic [CHAR_W-1:0] CH_CR  = 8'd13;

    localparam logic [CFG_INDEX_W-1:0] CFG_TEXT_COLOR = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLANK_CELL = 2'd1;

    localparam logic [CHAR_W-1:0] TEXT_COLOR_RST = 8'd7;
    localparam logic [CELL_W-1:0] BLANK_CELL_RST = 16'h0720;

    typedef struct packed {
        logic [REQ_W-1:0]      req_type;
        logic [CHAR_W-1:0]     char_code;
        logic                  end_of_string;
        logic [CELL_IDX_W-1:0] cell_index;
    } tccw_in_t;

    typedef struct packed {
        logic [OFFSET_W-1:0] cursor_offset;
        logic [OFFSET_W-1:0] display_start;
        logic [COLUMN_W-1:0] column;
        logic [ROW_W-1:0]    row;
        logic [CELL_W-1:0]   read_data;
    } tccw_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_REDUCE,
        ST_RD_WAIT,
        ST_CLEAR,
        ST_PUTC,
        ST_BLANK1,
        ST_TAB,
        ST_NEWLINE,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_SCR_BLANK,
        ST_DONE
    } tccw_state_t;

endpackage

`default_nettype wire

### hw/rtl/text_console_char_writer.sv
// ----------------------------------------------------------------------------
// text_console_char_writer
// Character-cell text console over a video memory of 16-bit cells.
// ----------------------------------------------------------------------------
// Channel  Handshake              Word
// in       in_valid / in_stall    tccw_in_t: request, character, string end, index
// out      out_valid / out_stall  tccw_out_t: cursor, display start, column, row, data
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_data (text color, blank cell)
//
// One request at a time. A put on a full line first starts a new line; a tab blanks
// cells to the next tab stop or line end. A newline on the last row scrolls: it
// blanks SCREEN_COLS cells, first copying the screen to cell 0 when it lies near
// the memory end. A clear writes all VMEM_CELLS cells. Reset clears control only;
// memory is undefined until a clear request. A stalled result waits in the output
// register; the next request is taken and holds in its last step until then.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_char_writer
    import tccw_pkg::*;
#(
    parameter int SCREEN_COLS = SCREEN_COLS_DEF,
    parameter int SCREEN_ROWS = SCREEN_ROWS_DEF,
    parameter int VMEM_CELLS  = VMEM_CELLS_DEF,
    parameter int TAB_STOP    = TAB_STOP_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  tccw_in_t               in_word,
    output logic                   out_valid,
    input  logic                   out_stall,
    output tccw_out_t              out_word,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int AW           = $clog2(VMEM_CELLS);
    localparam int CW           = $clog2(SCREEN_COLS + 1);
    localparam int RW           = $clog2(SCREEN_ROWS);
    localparam int PW           = $clog2(TAB_STOP);
    localparam int IW           = (AW + 1 > CELL_IDX_W) ? AW + 1 : CELL_IDX_W;
    localparam int SCREEN_CELLS = SCREEN_COLS * SCREEN_ROWS;
    localparam int CNT_W        = $clog2(SCREEN_CELLS);
    localparam int SC_MOD       = SCREEN_CELLS % VMEM_CELLS;
    localparam int COPY_AT_RAW  = VMEM_CELLS - SCREEN_CELLS - SCREEN_COLS;
    localparam int COPY_AT      = (COPY_AT_RAW < 0) ? 0 : COPY_AT_RAW;

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                               input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (AW+1)'(VMEM_CELLS))
        begin
            s = s - (AW+1)'(VMEM_CELLS);
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] wrap_sub(input logic [AW-1:0] a,
                                               input logic [AW-1:0] b);
        logic [AW:0] d;
        d = {1'b0, a} - {1'b0, b};
        if (d[AW])
        begin
            d = d + (AW+1)'(VMEM_CELLS);
        end
        return d[AW-1:0];
    endfunction

    logic [CELL_W-1:0] vram [VMEM_CELLS];
    logic [CELL_W-1:0] rdata_reg;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [AW-1:0]     mem_raddr;
    logic [CELL_W-1:0] mem_wdata;

    tccw_state_t       state_reg, state_next;
    logic [AW-1:0]     start_reg, start_next;
    logic [AW-1:0]     wo_reg, wo_next;
    logic [CW-1:0]     col_reg, col_next;
    logic [RW-1:0]     row_reg, row_next;
    logic [PW-1:0]     phase_reg, phase_next;
    logic [AW-1:0]     shown_reg, shown_next;
    logic [CHAR_W-1:0] color_reg, color_next;
    logic [CELL_W-1:0] blank_reg, blank_next;
    logic [AW-1:0]     ptr_reg, ptr_next;
    logic [AW-1:0]     src_reg, src_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [IW-1:0]     idx_reg, idx_next;
    logic [CHAR_W-1:0] ch_reg, ch_next;
    logic              eos_reg, eos_next;
    logic              pend_char_reg, pend_char_next;
    logic [CELL_W-1:0] rd_reg, rd_next;
    tccw_out_t         out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    logic [PW-1:0]     phase_inc;
    logic [CW-1:0]     col_inc;
    logic              need_copy;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            vram[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= vram[mem_raddr];
    end

    always_comb
    begin
        state_next     = state_reg;
        start_next     = start_reg;
        wo_next        = wo_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        phase_next     = phase_reg;
        shown_next     = shown_reg;
        color_next     = color_reg;
        blank_next     = blank_reg;
        ptr_next       = ptr_reg;
        src_next       = src_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        ch_next        = ch_reg;
        eos_next       = eos_reg;
        pend_char_next = pend_char_reg;
        rd_next        = rd_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        mem_we    = 1'b0;
        mem_waddr = wo_reg;
        mem_wdata = blank_reg;
        mem_raddr = src_reg;

        in_stall  = (state_reg != ST_IDLE);
        cfg_ready = 1'b1;

        phase_inc = (phase_reg == PW'(TAB_STOP - 1)) ? '0 : phase_reg + PW'(1);
        col_inc   = col_reg + CW'(1);
        need_copy = (start_reg >= AW'(COPY_AT));

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_TEXT_COLOR: color_next = cfg_data[CHAR_W-1:0];
                CFG_BLANK_CELL: blank_next = cfg_data;
                default:        ;
            endcase
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ch_next        = in_word.char_code;
                    eos_next       = 1'b0;
                    pend_char_next = 1'b0;
                    rd_next        = '0;
                    idx_next       = IW'(in_word.cell_index);
                    case (in_word.req_type)
                        REQ_PUT:
                        begin
                            if (in_word.char_code == CH_NUL)
                            begin
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                eos_next = in_word.end_of_string;
                                case (in_word.char_code)
                                    CH_BS:
                                    begin
                                        if (col_reg != '0)
                                        begin
                                            col_next   = col_reg - CW'(1);
                                            phase_next = (phase_reg == '0) ?
                                                PW'(TAB_STOP - 1) : phase_reg - PW'(1);
                                            wo_next    = wrap_sub(wo_reg, AW'(1));
                                            state_next = ST_BLANK1;
                                        end
                                        else
                                        begin
                                            state_next = ST_DONE;
                                        end
                                    end
                                    CH_HT:
                                    begin
                                        if (col_reg >= CW'(SCREEN_COLS - 1))
                                        begin
                                            state_next = ST_DONE;
                                        end
                                        else
                                        begin
                                            state_next = ST_TAB;
                                        end
                                    end
                                    CH_LF:
                                    begin
                                        wo_next    = wrap_sub(wo_reg, AW'(col_reg));
                                        col_next   = '0;
                                        phase_next = '0;
                                        state_next = ST_NEWLINE;
                                    end
                                    CH_CR:
                                    begin
                                        wo_next    = wrap_sub(wo_reg, AW'(col_reg));
                                        col_next   = '0;
                                        phase_next = '0;
                                        state_next = ST_DONE;
                                    end
                                    default:
                                    begin
                                        if (col_reg >= CW'(SCREEN_COLS))
                                        begin
                                            wo_next        = wrap_sub(wo_reg,
                                                                      AW'(SCREEN_COLS));
                                            col_next       = '0;
                                            phase_next     = '0;
                                            pend_char_next = 1'b1;
                                            state_next     = ST_NEWLINE;
                                        end
                                        else
                                        begin
                                            state_next = ST_PUTC;
                                        end
                                    end
                                endcase
                            end
                        end
                        REQ_READ:
                        begin
                            state_next = ST_RD_REDUCE;
                        end
                        REQ_CLEAR:
                        begin
                            ptr_next   = '0;
                            state_next = ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_RD_REDUCE:
            begin
                if (idx_reg >= IW'(VMEM_CELLS))
                begin
                    idx_next = idx_reg - IW'(VMEM_CELLS);
                end
                else
                begin
                    mem_raddr  = idx_reg[AW-1:0];
                    state_next = ST_RD_WAIT;
                end
            end

            ST_RD_WAIT:
            begin
                rd_next    = rdata_reg;
                state_next = ST_DONE;
            end

            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg;
                mem_wdata = blank_reg;
                ptr_next  = ptr_reg + AW'(1);
                if (ptr_reg == AW'(VMEM_CELLS - 1))
                begin
                    start_next = '0;
                    wo_next    = '0;
                    col_next   = '0;
                    row_next   = '0;
                    phase_next = '0;
                    shown_next = '0;
                    state_next = ST_DONE;
                end
            end

            ST_PUTC:
            begin
                mem_we     = 1'b1;
                mem_waddr  = wo_reg;
                mem_wdata  = {color_reg, ch_reg};
                wo_next    = wrap_add(wo_reg, AW'(1));
                col_next   = col_inc;
                phase_next = phase_inc;
                state_next = ST_DONE;
            end

            ST_BLANK1:
            begin
                mem_we     = 1'b1;
                mem_waddr  = wo_reg;
                state_next = ST_DONE;
            end

            ST_TAB:
            begin
                mem_we     = 1'b1;
                mem_waddr  = wo_reg;
                wo_next    = wrap_add(wo_reg, AW'(1));
                col_next   = col_inc;
                phase_next = phase_inc;
                if ((phase_inc == '0) || (col_inc == CW'(SCREEN_COLS)))
                begin
                    state_next = ST_DONE;
                end
            end

            ST_NEWLINE:
            begin
                cnt_next = '0;
                if (row_reg < RW'(SCREEN_ROWS - 1))
                begin
                    row_next   = row_reg + RW'(1);
                    wo_next    = wrap_add(wo_reg, AW'(SCREEN_COLS));
                    state_next = pend_char_reg ? ST_PUTC : ST_DONE;
                end
                else if (need_copy)
                begin
                    src_next   = start_reg;
                    ptr_next   = '0;
                    state_next = ST_COPY_RD;
                end
                else
                begin
                    ptr_next   = wrap_add(start_reg, AW'(SC_MOD));
                    state_next = ST_SCR_BLANK;
                end
            end

            ST_COPY_RD:
            begin
                mem_raddr  = src_reg;
                state_next = ST_COPY_WR;
            end

            ST_COPY_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg;
                mem_wdata = rdata_reg;
                ptr_next  = wrap_add(ptr_reg, AW'(1));
                src_next  = wrap_add(src_reg, AW'(1));
                cnt_next  = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(SCREEN_CELLS - 1))
                begin
                    wo_next    = wrap_sub(wo_reg, start_reg);
                    start_next = '0;
                    ptr_next   = AW'(SC_MOD);
                    cnt_next   = '0;
                    state_next = ST_SCR_BLANK;
                end
                else
                begin
                    state_next = ST_COPY_RD;
                end
            end

            ST_SCR_BLANK:
            begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg;
                mem_wdata = blank_reg;
                ptr_next  = wrap_add(ptr_reg, AW'(1));
                cnt_next  = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(SCREEN_COLS - 1))
                begin
                    start_next = wrap_add(start_reg, AW'(SCREEN_COLS));
                    wo_next    = wrap_add(wo_reg, AW'(SCREEN_COLS));
                    state_next = pend_char_reg ? ST_PUTC : ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    shown_next             = eos_reg ? wo_reg : shown_reg;
                    out_next.cursor_offset = OFFSET_W'(shown_next);
                    out_next.display_start = OFFSET_W'(start_reg);
                    out_next.column        = COLUMN_W'(col_reg);
                    out_next.row           = ROW_W'(row_reg);
                    out_next.read_data     = rd_reg;
                    out_valid_next         = 1'b1;
                    state_next             = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            start_reg     <= '0;
            wo_reg        <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            phase_reg     <= '0;
            shown_reg     <= '0;
            color_reg     <= TEXT_COLOR_RST;
            blank_reg     <= BLANK_CELL_RST;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            start_reg     <= start_next;
            wo_reg        <= wo_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            phase_reg     <= phase_next;
            shown_reg     <= shown_next;
            color_reg     <= color_next;
            blank_reg     <= blank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg       <= ptr_next;
        src_reg       <= src_next;
        cnt_reg       <= cnt_next;
        idx_reg       <= idx_next;
        ch_reg        <= ch_next;
        eos_reg       <= eos_next;
        pend_char_reg <= pend_char_next;
        rd_reg        <= rd_next;
        out_reg       <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

endmodule

`default_nettype wire

### hw/rtl/tccw_checker.sv
// ----------------------------------------------------------------------------
// tccw_checker
// Port-level checks of the text console character writer.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module tccw_checker
    import tccw_pkg::*;
#(
    parameter int SCREEN_COLS = SCREEN_COLS_DEF,
    parameter int SCREEN_ROWS = SCREEN_ROWS_DEF
)
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      in_valid,
    input wire logic      in_stall,
    input wire logic      out_valid,
    input wire logic      out_stall,
    input wire tccw_out_t out_word
)
;

    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_word), "stalled result word changed")
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall, "second word taken while busy")
    `ASSERT_ALWAYS(a_cursor_range, clk, rst_n, !out_valid || ((out_word.column <= SCREEN_COLS) && (out_word.row < SCREEN_ROWS)), "column or row out of range")

endmodule

bind text_console_char_writer tccw_checker #(
    .SCREEN_COLS(SCREEN_COLS),
    .SCREEN_ROWS(SCREEN_ROWS)
) u_tccw_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
);

`default_nettype wire
